FILE: hdl/smart_meter_telegram_checker_defines.svh
// ----------------------------------------------------------------------------
// Smart meter telegram checker assertion macros
// Shared assertion macros, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SMART_METER_TELEGRAM_CHECKER_DEFINES_SVH
`define SMART_METER_TELEGRAM_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define SMTC_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define SMTC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define SMTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SMTC_ASSERT_ALWAYS(label, expr, msg)
`define SMTC_ASSERT_IMPLY(label, ante, cons, msg)
`define SMTC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/smtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smart meter telegram checker package
// Types, character codes, verdict codes and CRC-16/ARC helper functions.
// ----------------------------------------------------------------------------
package smtc_pkg;

   localparam int BYTE_W    = 8;
   localparam int VERDICT_W = 3;
   localparam int CRC_W     = 16;

   localparam logic [CRC_W-1:0] ARC_POLY_REFLECTED = 16'hA001;

   localparam logic [VERDICT_W-1:0] VERDICT_OK       = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_START = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_END   = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_HEX  = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_MISMATCH = 3'd4;

   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_FIVE  = 8'h35;
   localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_of_record;
      logic              last_of_record;
   } item_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [CRC_W-1:0]     crc_computed;
      logic [CRC_W-1:0]     crc_received;
   } result_type;

   function automatic logic [CRC_W-1:0] arc_update(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ ARC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A);
   endfunction

   // Bit 4 of the result is set when the character is no hex digit.
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [4:0] h;
      h = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
         h = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h = 5'(c - 8'h37);
      end
      return h;
   endfunction

endpackage

FILE: hdl/smtc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smart meter telegram checker request channel
// Valid/ready channel that carries one record byte and its framing flags.
// ----------------------------------------------------------------------------
interface smtc_req_if;
   import smtc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first_of_record;
   logic              last_of_record;

   modport source (output valid, output data_byte, output first_of_record,
                   output last_of_record, input ready);
   modport sink   (input valid, input data_byte, input first_of_record,
                   input last_of_record, output ready);
endinterface

FILE: hdl/smtc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smart meter telegram checker response channel
// Valid/ready channel that carries one record verdict with both checksums.
// ----------------------------------------------------------------------------
interface smtc_rsp_if;
   import smtc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   logic [CRC_W-1:0]     crc_computed;
   logic [CRC_W-1:0]     crc_received;

   modport source (output valid, output verdict, output crc_computed,
                   output crc_received, input ready);
   modport sink   (input valid, input verdict, input crc_computed,
                   input crc_received, output ready);
endinterface

FILE: hdl/smtc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smart meter telegram checker core
// Record state, header check, running CRC and checksum tail matcher.
// ----------------------------------------------------------------------------
`include "smart_meter_telegram_checker_defines.svh"

module smtc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  smtc_pkg::item_type  item,
   output logic                result_valid,
   output smtc_pkg::result_type result
);
   import smtc_pkg::*;

   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_HEADER = 2'd1;
   localparam logic [1:0] PHASE_BODY   = 2'd2;

   localparam logic [2:0] TAIL_NONE      = 3'd0;
   localparam logic [2:0] TAIL_FIRST_HEX = 3'd1;
   localparam logic [2:0] TAIL_LAST_HEX  = 3'd4;
   localparam logic [2:0] TAIL_WAIT_CR   = 3'd5;
   localparam logic [2:0] TAIL_WAIT_LF   = 3'd6;

   localparam logic [2:0] POS_SLASH = 3'd0;
   localparam logic [2:0] POS_FIVE  = 3'd4;
   localparam logic [2:0] POS_DONE  = 3'd5;

   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       pos_ff, pos_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic [CRC_W-1:0] mark_ff, mark_in;
   logic [2:0]       tail_ff, tail_in;
   logic [CRC_W-1:0] recv_ff, recv_in;
   logic             hex_fault_ff, hex_fault_in;
   logic             given_ff, given_in;

   logic [VERDICT_W-1:0] verdict;
   logic                 good;
   logic                 fail;
   logic                 matched;
   logic [4:0]           hv;
   logic [BYTE_W-1:0]    c;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      mark_in      = mark_ff;
      tail_in      = tail_ff;
      recv_in      = recv_ff;
      hex_fault_in = hex_fault_ff;
      given_in     = given_ff;
      result_valid = 1'b0;
      verdict      = VERDICT_OK;
      good         = 1'b0;
      fail         = 1'b0;
      matched      = 1'b0;
      c            = item.data_byte;
      hv           = hex_value(c);
      if (step_valid) begin
         if (item.first_of_record || phase_in == PHASE_IDLE) begin
            pos_in       = POS_SLASH;
            crc_in       = '0;
            mark_in      = '0;
            tail_in      = TAIL_NONE;
            recv_in      = '0;
            hex_fault_in = 1'b0;
            given_in     = 1'b0;
            phase_in     = PHASE_HEADER;
         end
         if (given_in) begin
            if (item.last_of_record) begin
               phase_in = PHASE_IDLE;
            end
         end else begin
            crc_in = arc_update(crc_in, c);
            if (phase_in == PHASE_HEADER) begin
               if (pos_in == POS_SLASH) begin
                  good = (c == CH_SLASH);
               end else if (pos_in < POS_FIVE) begin
                  good = (c != CH_CR) && (c != CH_LF);
               end else begin
                  good = (c == CH_FIVE);
               end
               if (!good) begin
                  result_valid = 1'b1;
                  verdict      = VERDICT_NO_START;
               end else begin
                  if (pos_in >= POS_FIVE) begin
                     phase_in = PHASE_BODY;
                  end
                  pos_in = pos_in + 3'd1;
               end
            end
            if (!result_valid) begin
               if (tail_in >= TAIL_FIRST_HEX && tail_in <= TAIL_LAST_HEX) begin
                  if (is_alnum(c)) begin
                     if (hv[4]) begin
                        hex_fault_in = 1'b1;
                     end else begin
                        recv_in = {recv_in[CRC_W-5:0], hv[3:0]};
                     end
                     tail_in = tail_in + 3'd1;
                  end else begin
                     fail = 1'b1;
                  end
               end else if (tail_in == TAIL_WAIT_CR) begin
                  if (c == CH_CR) begin
                     tail_in = TAIL_WAIT_LF;
                  end else begin
                     fail = 1'b1;
                  end
               end else if (tail_in == TAIL_WAIT_LF) begin
                  if (c == CH_LF) begin
                     matched = 1'b1;
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  fail = 1'b1;
               end
               if (fail) begin
                  if (c == CH_BANG) begin
                     tail_in      = TAIL_FIRST_HEX;
                     mark_in      = crc_in;
                     recv_in      = '0;
                     hex_fault_in = 1'b0;
                  end else begin
                     tail_in = TAIL_NONE;
                  end
               end
               if (matched) begin
                  tail_in      = TAIL_NONE;
                  result_valid = 1'b1;
                  if (hex_fault_in) begin
                     verdict = VERDICT_BAD_HEX;
                  end else if (recv_in != mark_in) begin
                     verdict = VERDICT_MISMATCH;
                  end else begin
                     verdict = VERDICT_OK;
                  end
               end
            end
            if (!result_valid && item.last_of_record) begin
               result_valid = 1'b1;
               verdict = (phase_in == PHASE_HEADER) ? VERDICT_NO_START : VERDICT_NO_END;
            end
            if (item.last_of_record) begin
               phase_in = PHASE_IDLE;
            end
            if (result_valid) begin
               given_in = 1'b1;
            end
         end
      end
      result.verdict      = verdict;
      result.crc_computed = (verdict == VERDICT_OK || verdict == VERDICT_BAD_HEX ||
                             verdict == VERDICT_MISMATCH) ? mark_in : '0;
      result.crc_received = (verdict == VERDICT_OK || verdict == VERDICT_MISMATCH) ?
                            recv_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         pos_ff       <= POS_SLASH;
         crc_ff       <= '0;
         mark_ff      <= '0;
         tail_ff      <= TAIL_NONE;
         recv_ff      <= '0;
         hex_fault_ff <= 1'b0;
         given_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         mark_ff      <= mark_in;
         tail_ff      <= tail_in;
         recv_ff      <= recv_in;
         hex_fault_ff <= hex_fault_in;
         given_ff     <= given_in;
      end
   end

   `SMTC_ASSERT_ALWAYS(a_tail_range, tail_ff <= TAIL_WAIT_LF, "tail count out of range")
   `SMTC_ASSERT_IMPLY(a_body_pos, phase_ff == PHASE_BODY, pos_ff == POS_DONE, "body without full header")
   `SMTC_ASSERT_NEXT(a_given_set, step_valid && result_valid, given_ff, "verdict not recorded")

endmodule

FILE: hdl/smart_meter_telegram_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smart meter telegram checker
// Checks P1 style meter records byte by byte and gives one verdict each.
// ----------------------------------------------------------------------------
// Usage: bytes of a record enter on req_chan with first_of_record and
// last_of_record marking its ends. Each record yields one item on rsp_chan:
// the verdict (ok, no start, no end, bad hex, mismatch), the CRC-16/ARC
// from the slash through the exclamation mark, and the received checksum.
// The verdict comes on the byte that completes the CR LF after the checksum,
// on a bad header byte, or on the last byte; later bytes are dropped.
// An accepted byte waits in the input register, and its result is registered
// in the output register before it is offered on rsp_chan.
// One byte is taken per cycle while rsp_chan does not stall; the byte-wide CRC
// update and the tail match are both combinational between input and output register.
// When rsp_chan stalls, the result holds in the output register and the
// input register still takes one more byte; then req_chan.ready drops.
// Synchronous reset empties both registers and leaves the block waiting for
// the first byte of a new record.
// ----------------------------------------------------------------------------
`include "smart_meter_telegram_checker_defines.svh"

module smart_meter_telegram_checker (
   input logic       clock,
   input logic       reset,
   smtc_req_if.sink  req_chan,
   smtc_rsp_if.source rsp_chan
);
   import smtc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff;

   logic       advance;
   logic       step;
   logic       req_fire;
   logic       core_valid;
   result_type core_result;
   item_type   req_item;
   logic       rsp_code_ok;
   logic       rsp_framing;
   logic       rsp_crc_zero;

   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign req_item.data_byte       = req_chan.data_byte;
   assign req_item.first_of_record = req_chan.first_of_record;
   assign req_item.last_of_record  = req_chan.last_of_record;

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? (step && core_valid) : rsp_valid_ff;

   smtc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (step),
      .item         (in_item_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (step && core_valid) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.verdict      = rsp_item_ff.verdict;
   assign rsp_chan.crc_computed = rsp_item_ff.crc_computed;
   assign rsp_chan.crc_received = rsp_item_ff.crc_received;

   assign rsp_code_ok  = rsp_item_ff.verdict <= VERDICT_MISMATCH;
   assign rsp_framing  = rsp_valid_ff && (rsp_item_ff.verdict == VERDICT_NO_START ||
                                          rsp_item_ff.verdict == VERDICT_NO_END);
   assign rsp_crc_zero = (rsp_item_ff.crc_computed == '0) &&
                         (rsp_item_ff.crc_received == '0);

   `SMTC_ASSERT_NEXT(a_result_lands, step && core_valid, rsp_valid_ff, "result lost")
   `SMTC_ASSERT_IMPLY(a_verdict_code, rsp_valid_ff, rsp_code_ok, "bad verdict code")
   `SMTC_ASSERT_IMPLY(a_no_crc_on_framing, rsp_framing, rsp_crc_zero, "framing with crc")

endmodule
